// ===== sv/neighbor_edge_weights_defines.svh =====
// ----------------------------------------------------------------------------
// neighbor_edge_weights_defines
// assertion macros shared by the neighbor edge weight block
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_EDGE_WEIGHTS_DEFINES_SVH
`define NEIGHBOR_EDGE_WEIGHTS_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define NBW_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("nbw assertion failed");

// next-cycle implication
`define NBW_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("nbw assertion failed");

`endif

// ===== sv/nbw_pkg.sv =====
// ----------------------------------------------------------------------------
// nbw_pkg
// types and constants of the neighbor edge weight block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package nbw_pkg;

   localparam logic [31:0] INV_E_Q32     = 32'd1580030169;
   localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
   localparam logic [3:0]  SERIES_TERMS  = 4'd14;
   localparam logic [17:0] EXP_LIMIT     = 18'd12;
   localparam int          DIV_STEPS     = 9;

   typedef enum logic [1:0] {
      CSR_BETA  = 2'd0,
      CSR_GAMMA = 2'd1,
      CSR_WIDTH = 2'd2,
      CSR_NONE  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_ACCEPT,
      DP_UPDATE,
      DP_DIST,
      DP_SCALE,
      DP_TERM,
      DP_DIV,
      DP_ACC,
      DP_POW,
      DP_ROUND,
      DP_WEIGHT,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] need;
      logic       t_big;
      logic       div_last;
      logic       k_last;
      logic       pow_zero;
      logic       out_busy;
   } dp_status_type;

endpackage

// ===== sv/nbw_if.sv =====
// ----------------------------------------------------------------------------
// nbw_if
// channel interfaces: pixel request, weight response, register write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface nbw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;
   logic       frame_start;
   modport source (output valid, blue, green, red, frame_start, input ready);
   modport sink   (input valid, blue, green, red, frame_start, output ready);
endinterface

interface nbw_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] left_weight;
   logic [23:0] upleft_weight;
   logic [23:0] up_weight;
   logic [23:0] upright_weight;
   modport source (output valid, left_weight, upleft_weight, up_weight, upright_weight,
                   input ready);
   modport sink   (input valid, left_weight, upleft_weight, up_weight, upright_weight,
                   output ready);
endinterface

interface nbw_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/nbw_datapath.sv =====
// ----------------------------------------------------------------------------
// nbw_datapath
// line store, pixel registers, shared exp unit and weight output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nbw_datapath
   import nbw_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [7:0]    blue,
   input  logic [7:0]    green,
   input  logic [7:0]    red,
   input  logic          frame_start,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [23:0]   left_weight,
   output logic [23:0]   upleft_weight,
   output logic [23:0]   up_weight,
   output logic [23:0]   upright_weight
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_COL = AW'(MAX_WIDTH - 1);

   logic [31:0] beta_ff;
   logic [15:0] gamma_ff;
   logic [11:0] width_ff;

   logic [23:0] row_mem [MAX_WIDTH];
   logic [23:0] rd0_ff, rd1_ff;
   logic [23:0] left_ff, upleft_ff, cur_pix_ff;
   logic [23:0] nbr_ff [4];
   logic [AW-1:0] col_ff, cur_col_ff;
   logic        first_ff;
   logic [3:0]  need_ff;

   logic [17:0] d2_ff;
   logic [49:0] t_ff;
   logic [32:0] term_ff;
   logic [33:0] sum_ff;
   logic [35:0] dnum_ff;
   logic [3:0]  rem_ff;
   logic [3:0]  dcnt_ff;
   logic [3:0]  k_ff;
   logic [3:0]  pcnt_ff;
   logic [16:0] e_ff;
   logic [23:0] g2_ff;
   logic [23:0] wt_ff [4];
   logic        out_valid_ff;
   logic [23:0] out_ff [4];

   // accept-time row bookkeeping
   logic [AW-1:0] col_now;
   logic          first_now;
   logic [13:0]   w14;
   logic          has_right, has_left, has_up;
   logic [AW-1:0] addr1;

   always_comb begin
      col_now   = frame_start ? '0 : col_ff;
      first_now = frame_start | first_ff;
      if (width_ff == 12'd0) begin
         w14 = 14'd1;
      end else if ({2'b0, width_ff} > MAX_W14) begin
         w14 = MAX_W14;
      end else begin
         w14 = {2'b0, width_ff};
      end
      has_right = (14'(col_now) + 14'd1) < w14;
      has_left  = col_now != '0;
      has_up    = !first_now;
      addr1     = (col_now == LAST_COL) ? '0 : col_now + AW'(1);
   end

   // squared color distance to the selected neighbor
   logic [17:0] d2_calc;
   always_comb begin
      logic signed [8:0]  dd;
      logic signed [17:0] sq;
      logic [17:0] acc;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         dd  = $signed({1'b0, cur_pix_ff[8*i +: 8]}) - $signed({1'b0, nbr_ff[cmd.sel][8*i +: 8]});
         sq  = dd * dd;
         acc = acc + unsigned'(sq);
      end
      d2_calc = acc;
   end

   logic [65:0] term_prod;
   logic [32:0] term_next;
   logic [65:0] pow_prod;
   logic [35:0] div_num;
   logic [3:0]  div_rem;
   logic [34:0] e_sum;
   logic [33:0] st_prod;
   logic [47:0] dg_prod;
   logic [48:0] g2_prod;

   always_comb begin
      logic [4:0] r;
      term_prod = {1'b0, 65'(term_ff) * 65'(t_ff[31:0])} + (66'd1 << 31);
      term_next = term_prod[64:32];
      pow_prod  = 66'(sum_ff) * 66'(INV_E_Q32) + (66'd1 << 31);
      div_num   = dnum_ff;
      div_rem   = rem_ff;
      // four quotient bits per cycle
      for (int i = 0; i < 4; i++) begin
         r       = {div_rem, div_num[35]};
         div_num = {div_num[34:0], 1'b0};
         if (r >= {1'b0, k_ff}) begin
            r          = r - {1'b0, k_ff};
            div_num[0] = 1'b1;
         end
         div_rem = r[3:0];
      end
      e_sum   = 35'(sum_ff) + 35'd32768;
      st_prod = 34'(gamma_ff) * 34'(e_ff) + 34'd128;
      dg_prod = 48'(g2_ff) * 48'(e_ff) + (48'd1 << 23);
      g2_prod = 49'(gamma_ff) * 49'(INV_SQRT2_Q32) + (49'd1 << 23);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff      <= '0;
         gamma_ff     <= 16'd12800;
         width_ff     <= 12'd2048;
         left_ff      <= '0;
         upleft_ff    <= '0;
         col_ff       <= '0;
         first_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_BETA:  beta_ff  <= csr_data;
               CSR_GAMMA: gamma_ff <= csr_data[15:0];
               CSR_WIDTH: width_ff <= csr_data[11:0];
               default:   ;
            endcase
         end
         if (out_valid_ff && rsp_ready && cmd.op != DP_EMIT) begin
            out_valid_ff <= 1'b0;
         end
         case (cmd.op)
            DP_ACCEPT: begin
               cur_pix_ff <= {red, green, blue};
               cur_col_ff <= col_now;
               need_ff    <= {has_right & has_up, has_up, has_left & has_up, has_left};
               rd0_ff     <= row_mem[col_now];
               rd1_ff     <= row_mem[addr1];
               if (has_right) begin
                  col_ff   <= col_now + AW'(1);
                  first_ff <= first_now;
               end else begin
                  col_ff   <= '0;
                  first_ff <= 1'b0;
               end
            end
            DP_UPDATE: begin
               nbr_ff[0] <= left_ff;
               nbr_ff[1] <= upleft_ff;
               nbr_ff[2] <= rd0_ff;
               nbr_ff[3] <= rd1_ff;
               left_ff   <= cur_pix_ff;
               upleft_ff <= rd0_ff;
               row_mem[cur_col_ff] <= cur_pix_ff;
               g2_ff     <= g2_prod[47:24];
               for (int i = 0; i < 4; i++) begin
                  wt_ff[i] <= '0;
               end
            end
            DP_DIST: d2_ff <= d2_calc;
            DP_SCALE: begin
               t_ff    <= 50'(beta_ff) * 50'(d2_ff);
               term_ff <= 33'h1_0000_0000;
               sum_ff  <= 34'h1_0000_0000;
               k_ff    <= 4'd1;
            end
            DP_TERM: begin
               dnum_ff <= 36'(term_next) + 36'(k_ff >> 1);
               rem_ff  <= '0;
               dcnt_ff <= '0;
            end
            DP_DIV: begin
               dnum_ff <= div_num;
               rem_ff  <= div_rem;
               dcnt_ff <= dcnt_ff + 4'd1;
            end
            DP_ACC: begin
               term_ff <= dnum_ff[32:0];
               if (k_ff[0]) begin
                  sum_ff <= sum_ff - {1'b0, dnum_ff[32:0]};
               end else begin
                  sum_ff <= sum_ff + {1'b0, dnum_ff[32:0]};
               end
               k_ff    <= k_ff + 4'd1;
               pcnt_ff <= t_ff[35:32];
            end
            DP_POW: begin
               sum_ff  <= pow_prod[65:32];
               pcnt_ff <= pcnt_ff - 4'd1;
            end
            DP_ROUND: e_ff <= status.t_big ? '0 : e_sum[32:16];
            DP_WEIGHT: begin
               if (cmd.sel[0]) begin
                  wt_ff[cmd.sel] <= dg_prod[47:24];
               end else begin
                  wt_ff[cmd.sel] <= st_prod[31:8];
               end
            end
            DP_EMIT: begin
               for (int i = 0; i < 4; i++) begin
                  out_ff[i] <= wt_ff[i];
               end
               out_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      status.need     = need_ff;
      status.t_big    = t_ff[49:32] >= EXP_LIMIT;
      status.div_last = dcnt_ff == 4'(DIV_STEPS - 1);
      status.k_last   = k_ff == SERIES_TERMS;
      status.pow_zero = pcnt_ff == 4'd0;
      status.out_busy = out_valid_ff && !rsp_ready;
   end

   assign rsp_valid      = out_valid_ff;
   assign left_weight    = out_ff[0];
   assign upleft_weight  = out_ff[1];
   assign up_weight      = out_ff[2];
   assign upright_weight = out_ff[3];

endmodule

// ===== sv/nbw_ctrl.sv =====
// ----------------------------------------------------------------------------
// nbw_ctrl
// sequencer: steps the shared exp unit over the four neighbors of a pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "neighbor_edge_weights_defines.svh"
module nbw_ctrl
   import nbw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_UPDATE, S_PICK, S_DIST, S_SCALE, S_TERM, S_DIV,
      S_ACC, S_POW, S_ROUND, S_WEIGHT, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd.op   = DP_IDLE;
      cmd.sel  = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_ACCEPT;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.op   = DP_UPDATE;
            idx_in   = 2'd0;
            state_in = S_PICK;
         end
         S_PICK: begin
            if (status.need[idx_ff]) begin
               state_in = S_DIST;
            end else if (idx_ff == 2'd3) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_DIST: begin
            cmd.op   = DP_DIST;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.op   = DP_SCALE;
            state_in = S_TERM;
         end
         S_TERM: begin
            // saturated exponent skips the series
            if (status.t_big) begin
               state_in = S_ROUND;
            end else begin
               cmd.op   = DP_TERM;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = DP_DIV;
            if (status.div_last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.op   = DP_ACC;
            state_in = status.k_last ? S_POW : S_TERM;
         end
         S_POW: begin
            if (status.pow_zero) begin
               state_in = S_ROUND;
            end else begin
               cmd.op = DP_POW;
            end
         end
         S_ROUND: begin
            cmd.op   = DP_ROUND;
            state_in = S_WEIGHT;
         end
         S_WEIGHT: begin
            cmd.op = DP_WEIGHT;
            if (idx_ff == 2'd3) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_PICK;
            end
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.op   = DP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

   `NBW_ASSERT_NEXT(a_accept_update, req_valid && req_ready, state_ff == S_UPDATE)
   `NBW_ASSERT_IMP(a_weight_after_round, state_ff == S_WEIGHT, $past(state_ff) == S_ROUND)
   `NBW_ASSERT_IMP(a_emit_free, cmd.op == DP_EMIT, !status.out_busy)

endmodule

// ===== sv/neighbor_edge_weights.sv =====
// ----------------------------------------------------------------------------
// neighbor_edge_weights
// graph-cut neighbor edge weights over a raster of bgr pixels
// ----------------------------------------------------------------------------
// channel   dir  fields
// req_chan  in   blue, green, red, frame_start
// rsp_chan  out  left/upleft/up/upright weights; left/up q8.16, upleft/upright q16.8
// csr_chan  in   index 0 beta, 1 gamma, 2 width; data
//
// one pixel at a time through a shared exp unit; a neighbor outside the image
// is skipped, a saturated exponent skips the series, else 14 series terms run
// and the result is scaled by 1/e n times (n = integer part of beta*d2)
// synchronous reset, no clearing pass; a waiting result does not block
// the sequencer until the next pixel is done
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module neighbor_edge_weights
   import nbw_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input logic clock,
   input logic reset,
   nbw_req_if.sink   req_chan,
   nbw_rsp_if.source rsp_chan,
   nbw_csr_if.sink   csr_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_chan.ready = 1'b1;

   nbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nbw_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .blue           (req_chan.blue),
      .green          (req_chan.green),
      .red            (req_chan.red),
      .frame_start    (req_chan.frame_start),
      .csr_write      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .left_weight    (rsp_chan.left_weight),
      .upleft_weight  (rsp_chan.upleft_weight),
      .up_weight      (rsp_chan.up_weight),
      .upright_weight (rsp_chan.upright_weight)
   );

endmodule
